@@ rtl/mts_pkg.sv @@
// package for the min-tracking stack: operation and status codes, field widths
// and default sizes shared by the interfaces and all modules
// no dependencies
package mts_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_WIDTH_DEF  = 32;
    localparam int FIELD_W         = 32;
    localparam int COUNT_W         = 7;
    localparam int STATUS_W        = 2;
    localparam int Q_DEPTH         = 2;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

endpackage

@@ rtl/mts_if.sv @@
// valid/ready channel interfaces for the min-tracking stack
// depends on mts_pkg for field widths
interface mts_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic signed [mts_pkg::FIELD_W-1:0]   push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface mts_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mts_pkg::FIELD_W-1:0]   popped_value;
    logic signed [mts_pkg::FIELD_W-1:0]   current_min;
    logic                                 min_valid;
    logic        [mts_pkg::STATUS_W-1:0]  status;
    logic        [mts_pkg::COUNT_W-1:0]   element_count;

    modport source (output valid, output popped_value, output current_min,
                    output min_valid, output status, output element_count, input ready);
    modport sink   (input valid, input popped_value, input current_min,
                    input min_valid, input status, input element_count, output ready);
endinterface

@@ rtl/mts_front.sv @@
// front stage: accepts command items, decodes the operation and fits the value
// to the internal word width; depends on mts_pkg and mts_cmd_if
module mts_front #(
    parameter int WORD_WIDTH = mts_pkg::WORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mts_cmd_if.sink                       i_cmd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output mts_pkg::t_op                  o_op,
    output logic signed [WORD_WIDTH-1:0]  o_value
);
    import mts_pkg::*;

    logic                          r_valid;
    t_op                           r_op;
    logic signed [WORD_WIDTH-1:0]  r_value;
    logic                          take;
    t_op                           dec_op;

    assign i_cmd.ready = !r_valid || i_ready;
    assign take        = i_cmd.valid && i_cmd.ready;
    assign dec_op      = t_op'(i_cmd.operation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_op    <= dec_op;
                // value only matters for a push
                r_value <= (dec_op == OP_PUSH) ? WORD_WIDTH'(i_cmd.push_value) : '0;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_value = r_value;

endmodule

@@ rtl/mts_queue.sv @@
// short fifo between front and back stages
// depends on mts_pkg for the queue depth
module mts_queue #(
    parameter int DW = mts_pkg::WORD_WIDTH_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);
    import mts_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [DW-1:0]    r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = r_cnt != CNT_W'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/mts_back.sv @@
// back stage: executes push and pop on the data and minima stacks, keeps both
// tops in registers and drives the result register; depends on mts_pkg, mts_rsp_if
module mts_back #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = mts_pkg::WORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  mts_pkg::t_op                  i_q_op,
    input  logic signed [WORD_WIDTH-1:0]  i_q_value,
    mts_rsp_if.source                     o_rsp
);
    import mts_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic {
        S_EXEC,
        S_LOAD
    } t_state;

    // stack storage, top entries mirrored in r_dtop / r_mtop
    logic signed [WORD_WIDTH-1:0] r_dmem [STACK_DEPTH];
    logic signed [WORD_WIDTH-1:0] r_mmem [STACK_DEPTH];
    logic signed [WORD_WIDTH-1:0] r_drd;
    logic signed [WORD_WIDTH-1:0] r_mrd;

    t_state                       r_state,  n_state;
    logic [CNT_W-1:0]             r_dcnt,   n_dcnt;
    logic [CNT_W-1:0]             r_mcnt,   n_mcnt;
    logic signed [WORD_WIDTH-1:0] r_dtop,   n_dtop;
    logic signed [WORD_WIDTH-1:0] r_mtop,   n_mtop;
    logic signed [WORD_WIDTH-1:0] r_popped, n_popped;
    logic                         r_mpop,   n_mpop;

    logic                         r_ov,     n_ov;
    logic signed [FIELD_W-1:0]    r_pv,     n_pv;
    logic signed [FIELD_W-1:0]    r_cm,     n_cm;
    logic                         r_mv,     n_mv;
    t_status                      r_status, n_status;
    logic [COUNT_W-1:0]           r_ecnt,   n_ecnt;

    logic              out_free;
    logic              take;
    logic              is_push;
    logic              full;
    logic              empty;
    logic              push_ok;
    logic              pop_ok;
    logic              min_push;
    logic              mpop;
    logic              load_out;
    logic [ADDR_W-1:0] d_waddr;
    logic [ADDR_W-1:0] m_waddr;
    logic [ADDR_W-1:0] d_raddr;
    logic [ADDR_W-1:0] m_raddr;

    assign out_free  = !r_ov || o_rsp.ready;
    assign o_q_ready = (r_state == S_EXEC) && out_free;
    assign take      = o_q_ready && i_q_valid;
    assign is_push   = i_q_op == OP_PUSH;
    assign full      = r_dcnt == CNT_W'(STACK_DEPTH);
    assign empty     = r_dcnt == '0;
    assign push_ok   = take && is_push && !full;
    assign pop_ok    = take && !is_push && !empty;
    assign min_push  = (r_mcnt == '0) || (i_q_value <= r_mtop);
    assign mpop      = (r_mcnt != '0) && (r_mtop == r_dtop);

    assign d_waddr = ADDR_W'(r_dcnt);
    assign m_waddr = ADDR_W'(r_mcnt);
    // entries just below the tops, used after a pop
    assign d_raddr = ADDR_W'(r_dcnt - CNT_W'(2));
    assign m_raddr = ADDR_W'(r_mcnt - CNT_W'(2));

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_dmem[d_waddr] <= i_q_value;
        end
        if (push_ok && min_push) begin
            r_mmem[m_waddr] <= i_q_value;
        end
        if (pop_ok) begin
            r_drd <= r_dmem[d_raddr];
            r_mrd <= r_mmem[m_raddr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_dcnt   = r_dcnt;
        n_mcnt   = r_mcnt;
        n_dtop   = r_dtop;
        n_mtop   = r_mtop;
        n_popped = r_popped;
        n_mpop   = r_mpop;
        n_ov     = r_ov && !o_rsp.ready;
        n_pv     = r_pv;
        n_cm     = r_cm;
        n_mv     = r_mv;
        n_status = r_status;
        n_ecnt   = r_ecnt;
        load_out = 1'b0;

        unique case (r_state)
            S_EXEC: begin
                if (push_ok) begin
                    n_dcnt = r_dcnt + CNT_W'(1);
                    n_dtop = i_q_value;
                    if (min_push) begin
                        n_mcnt = r_mcnt + CNT_W'(1);
                        n_mtop = i_q_value;
                    end
                end
                if (pop_ok) begin
                    n_dcnt   = r_dcnt - CNT_W'(1);
                    n_mcnt   = r_mcnt - CNT_W'(mpop);
                    n_popped = r_dtop;
                    n_mpop   = mpop;
                    n_state  = S_LOAD;
                end
                if (take && !pop_ok) begin
                    load_out = 1'b1;
                    n_pv     = '0;
                    if (!is_push) begin
                        n_status = ST_POP_EMPTY;
                    end else if (full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        n_status = ST_OK;
                    end
                end
            end
            S_LOAD: begin
                // read data for the new tops has arrived
                if (r_dcnt != '0) begin
                    n_dtop = r_drd;
                end
                if (r_mpop && r_mcnt != '0) begin
                    n_mtop = r_mrd;
                end
                load_out = 1'b1;
                n_pv     = FIELD_W'(r_popped);
                n_status = ST_OK;
                n_state  = S_EXEC;
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase

        if (load_out) begin
            n_ov   = 1'b1;
            n_mv   = (n_mcnt != '0) && (n_dcnt != '0);
            n_cm   = n_mv ? FIELD_W'(n_mtop) : '0;
            n_ecnt = COUNT_W'(n_dcnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EXEC;
            r_dcnt  <= '0;
            r_mcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dcnt   <= n_dcnt;
            r_mcnt   <= n_mcnt;
            r_dtop   <= n_dtop;
            r_mtop   <= n_mtop;
            r_popped <= n_popped;
            r_mpop   <= n_mpop;
            r_ov     <= n_ov;
            r_pv     <= n_pv;
            r_cm     <= n_cm;
            r_mv     <= n_mv;
            r_status <= n_status;
            r_ecnt   <= n_ecnt;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.popped_value  = r_pv;
    assign o_rsp.current_min   = r_cm;
    assign o_rsp.min_valid     = r_mv;
    assign o_rsp.status        = r_status;
    assign o_rsp.element_count = r_ecnt;

endmodule

@@ rtl/min_tracking_stack_top.sv @@
// min-tracking stack: bounded lifo of signed words with constant-time minimum
// top level tying front stage, queue and back stage together
// depends on mts_pkg, mts_if, mts_front, mts_queue, mts_back
//
// usage
//   i_cmd carries one item per push or pop (operation, push_value); o_rsp gives
//   exactly one result per item, in order: popped value, current minimum and
//   its valid flag, status and the element count after the item
//   pop on an empty stack and push on a full one leave the stack as it was
//   and report an error status
// pipeline and throughput
//   the front register and the queue sit ahead of the back stage; a push is
//   done in back-stage state S_EXEC, a pop also needs S_LOAD because the
//   entries under the tops come from the stack memories through their
//   registered read port; sustained rate while o_rsp is ready: one push per
//   cycle, and the back stage takes no new item while it finishes a pop
// reset and stall
//   i_rst_n (synchronous, active low) empties both stacks and drops all
//   queued items; memory contents are left as they are
//   a stalled o_rsp holds the result register; the queue and front register
//   keep taking items until they fill, then i_cmd.ready falls
module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = mts_pkg::WORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_cmd_if.sink   i_cmd,
    mts_rsp_if.source o_rsp
);
    import mts_pkg::*;

    // front to queue
    logic                          fr_valid;
    logic                          fr_ready;
    t_op                           fr_op;
    logic signed [WORD_WIDTH-1:0]  fr_value;

    // queue to back, op bit on top of the word
    logic                          q_valid;
    logic                          q_ready;
    logic [WORD_WIDTH:0]           q_wdata;
    logic [WORD_WIDTH:0]           q_rdata;
    t_op                           q_op;
    logic signed [WORD_WIDTH-1:0]  q_value;

    mts_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_op    (fr_op),
        .o_value (fr_value)
    );

    assign q_wdata = {fr_op, fr_value};

    mts_queue #(
        .DW (WORD_WIDTH + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  (q_wdata),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_rdata)
    );

    assign q_op    = t_op'(q_rdata[WORD_WIDTH]);
    assign q_value = q_rdata[WORD_WIDTH-1:0];

    mts_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_op    (q_op),
        .i_q_value (q_value),
        .o_rsp     (o_rsp)
    );

endmodule
